FILE: rtl/rrs_pkg.sv
package rrs_pkg;

  localparam int unsigned MAX_PIXELS = 1024;
  localparam int unsigned MAX_RUNS   = 64;
  localparam int unsigned PIXEL_BITS = 8;
  localparam int unsigned PAT_LEN    = 5;

  localparam int unsigned VALUE_SPAN = 1 << PIXEL_BITS;
  localparam int unsigned POS_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned START_W    = $clog2(MAX_PIXELS);
  localparam int unsigned LEN_W      = POS_W;
  localparam int unsigned CNT_W      = $clog2(MAX_RUNS + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_RUNS);
  localparam int unsigned TYPE_W     = CNT_W;

  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = $clog2(PAT_LEN * 4);
  localparam int unsigned REG_IDX_W  = APB_AW - 2;
  // Number of pattern registers; register indexes at or above it are unmapped.
  localparam logic [REG_IDX_W-1:0] REG_COUNT = REG_IDX_W'(PAT_LEN);

  typedef logic [TYPE_W-1:0] type_t;
  typedef type_t [PAT_LEN-1:0] pat_t;

  // Element 0 is the first position of the window.
  localparam pat_t PAT_RESET = {TYPE_W'(1), TYPE_W'(3), TYPE_W'(2), TYPE_W'(3), TYPE_W'(1)};

  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    logic [START_W-1:0]    start;
    logic [LEN_W-1:0]      len;
  } run_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] run_cnt;
    logic             overflow;
  } ld_status_t;

  typedef struct packed {
    logic [CNT_W-1:0]   segment_index;
    logic [TYPE_W-1:0]  segment_type;
    logic [LEN_W-1:0]   pixel_count;
    logic [START_W-1:0] midpoint;
    logic               pattern_found;
    logic               overflow;
    logic               last_segment;
  } seg_t;

endpackage

FILE: rtl/rrs_pixel_if.sv
interface rrs_pixel_if import rrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic                  last_pixel;

  modport source (output valid, output pixel_value, output last_pixel, input ready);
  modport sink (input valid, input pixel_value, input last_pixel, output ready);
endinterface

FILE: rtl/rrs_seg_if.sv
interface rrs_seg_if import rrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   segment_index;
  logic [TYPE_W-1:0]  segment_type;
  logic [LEN_W-1:0]   pixel_count;
  logic [START_W-1:0] midpoint;
  logic               pattern_found;
  logic               overflow;
  logic               last_segment;

  modport source (output valid, output segment_index, output segment_type,
                  output pixel_count, output midpoint, output pattern_found,
                  output overflow, output last_segment, input ready);
  modport sink (input valid, input segment_index, input segment_type,
                input pixel_count, input midpoint, input pattern_found,
                input overflow, input last_segment, output ready);
endinterface

FILE: rtl/rrs_ram.sv
module rrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rrs_cfg.sv
module rrs_cfg import rrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output pat_t              pattern_o
);

  pat_t                 pat_q;
  pat_t                 pat_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_hit;

  assign reg_idx = paddr[APB_AW-1:2];
  assign reg_hit = reg_idx < REG_COUNT;
  assign pready  = 1'b1;

  always_comb begin
    pat_d = pat_q;
    if (psel && penable && pwrite && reg_hit) begin
      pat_d[reg_idx] = pwdata[TYPE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = APB_DW'(pat_q[reg_idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= PAT_RESET;
    end else begin
      pat_q <= pat_d;
    end
  end

  assign pattern_o = pat_q;

endmodule

FILE: rtl/rrs_loader.sv
module rrs_loader import rrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [PIXEL_BITS-1:0] value_i,
  input  logic                  clear_i,
  input  logic                  map_clr_i,
  input  logic [PIXEL_BITS-1:0] map_clr_idx_i,
  input  logic [PIXEL_BITS-1:0] map_idx_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output logic                  map_bit_o,
  output ld_status_t            status_o,
  output run_rec_t              rd_o
);

  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [PIXEL_BITS-1:0] cur_val_q, cur_val_d;
  logic [LEN_W-1:0]      cur_len_q, cur_len_d;

  logic                  new_run;
  logic                  open_run;
  logic                  grow;
  logic [CNT_W-1:0]      cnt_m1;
  logic [IDX_W-1:0]      len_waddr;
  logic [LEN_W-1:0]      len_wdata;
  logic [PIXEL_BITS-1:0] map_waddr;
  logic [PIXEL_BITS+START_W-1:0] run_rdata;

  assign new_run = (cnt_q == '0) || (value_i != cur_val_q);
  assign cnt_m1  = cnt_q - CNT_W'(1);

  always_comb begin
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    cur_val_d = cur_val_q;
    cur_len_d = cur_len_q;
    open_run  = 1'b0;
    grow      = 1'b0;
    if (take_i && !ovf_q) begin
      priority if (pos_q >= POS_W'(MAX_PIXELS)) begin
        ovf_d = 1'b1;
      end else if (new_run && (cnt_q >= CNT_W'(MAX_RUNS))) begin
        ovf_d = 1'b1;
      end else if (new_run) begin
        open_run  = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        cur_val_d = value_i;
        cur_len_d = LEN_W'(1);
        pos_d     = pos_q + POS_W'(1);
      end else begin
        grow      = 1'b1;
        cur_len_d = cur_len_q + LEN_W'(1);
        pos_d     = pos_q + POS_W'(1);
      end
    end
    if (clear_i) begin
      pos_d     = '0;
      cnt_d     = '0;
      ovf_d     = 1'b0;
      cur_val_d = '0;
      cur_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      cur_val_q <= '0;
      cur_len_q <= '0;
    end else begin
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      cur_val_q <= cur_val_d;
      cur_len_q <= cur_len_d;
    end
  end

  // A new run writes at the next free slot; a longer run rewrites its own slot.
  assign len_waddr = open_run ? cnt_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign len_wdata = open_run ? LEN_W'(1) : cur_len_q + LEN_W'(1);

  // Mark a value when a run opens; zero entries while the map is walked.
  assign map_waddr = open_run ? value_i : map_clr_idx_i;

  rrs_ram #(
    .WIDTH (PIXEL_BITS + START_W),
    .DEPTH (MAX_RUNS)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (open_run),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({value_i, pos_q[START_W-1:0]}),
    .raddr_i (rd_idx_i),
    .rdata_o (run_rdata)
  );

  rrs_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_RUNS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (open_run || grow),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (rd_idx_i),
    .rdata_o (rd_o.len)
  );

  rrs_ram #(
    .WIDTH (1),
    .DEPTH (VALUE_SPAN)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (open_run || map_clr_i),
    .waddr_i (map_waddr),
    .wdata_i (open_run),
    .raddr_i (map_idx_i),
    .rdata_o (map_bit_o)
  );

  assign rd_o.value = run_rdata[PIXEL_BITS+START_W-1:START_W];
  assign rd_o.start = run_rdata[START_W-1:0];

  assign status_o.run_cnt = cnt_q;
  assign status_o.overflow = ovf_q;

endmodule

FILE: rtl/row_run_segmenter_pattern_match_core.sv
// Channel  | Direction | Payload                                   | Handshake
// pix_i    | in        | pixel_value, last_pixel                   | valid/ready
// seg_o    | out       | segment_index, segment_type, pixel_count, | valid/ready
//          |           | midpoint, pattern_found, overflow,        |
//          |           | last_segment                              |
// APB      | in        | pattern registers at byte address 4*i     | psel/penable, pready=1
//
// Sequence: pixels of a row are taken one per cycle while in LOAD. After the
// last pixel a PRIME state primes the value map read, then the rank sweep
// walks the 2**PIXEL_BITS value map (zeroing each entry as it goes), then a
// type pass steps each run through VAL, RANK and USE and the emit pass through
// VAL, RANK, USE and HOLD (one shared value-to-rank read path), then CLEAR.
// Reset: asynchronous, active low; an INIT pass then zeroes the value map,
// and pixel requests are held off until it ends.
// Stalls: a held result simply waits in the output register.
module row_run_segmenter_pattern_match_core import rrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrs_pixel_if.sink         pix_i,
  rrs_seg_if.source         seg_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Sequencer: INIT zeroes the value map, LOAD takes pixels, PRIME and SWEEP
  // build the rank table, then VAL/RANK/USE walk the runs twice (types and
  // match, then results), HOLD waits on the sink, CLEAR drops the row state.
  typedef enum logic [3:0] {
    S_INIT,
    S_LOAD,
    S_PRIME,
    S_SWEEP,
    S_VAL,
    S_RANK,
    S_USE,
    S_HOLD,
    S_CLEAR
  } state_e;

  state_e                state_q, state_d;
  logic [PIXEL_BITS-1:0] u_q, u_d;
  type_t                 acc_q, acc_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic                  emit_q, emit_d;
  logic                  found_q, found_d;
  pat_t                  win_q, win_d;
  seg_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  pat_t       pattern;
  logic       pix_take;
  logic       clear;
  logic       map_clr;
  logic       rank_we;
  logic       map_bit;
  ld_status_t status;
  run_rec_t   rec;
  type_t      run_type;
  pat_t       win_shift;
  logic       k_last;
  logic [CNT_W-1:0] k_next;

  rrs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pattern_o (pattern)
  );

  assign pix_i.ready = (state_q == S_LOAD);
  assign pix_take    = pix_i.valid && pix_i.ready;

  // The map is read one value ahead (u_d), so its registered bit lines up
  // with u_q during the sweep; u_q is also the entry being zeroed.
  rrs_loader u_loader (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (pix_take),
    .value_i       (pix_i.pixel_value),
    .clear_i       (clear),
    .map_clr_i     (map_clr),
    .map_clr_idx_i (u_q),
    .map_idx_i     (u_d),
    .rd_idx_i      (k_q),
    .map_bit_o     (map_bit),
    .status_o      (status),
    .rd_o          (rec)
  );

  // Rank table: entry v holds 1 plus the count of present values below v.
  // Its read address is the stored run value, so the type of run k comes through
  // the registered run RAM read and then this registered read, in time for S_USE.
  rrs_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (VALUE_SPAN)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (u_q),
    .wdata_i (acc_q + TYPE_W'(1)),
    .raddr_i (rec.value),
    .rdata_o (run_type)
  );

  // Oldest type sits in element 0, lining up with the first pattern position.
  assign win_shift = {run_type, win_q[PAT_LEN-1:1]};
  assign k_next    = CNT_W'(k_q) + CNT_W'(1);
  assign k_last    = (k_next == status.run_cnt);

  always_comb begin
    state_d     = state_q;
    u_d         = u_q;
    acc_d       = acc_q;
    k_d         = k_q;
    emit_d      = emit_q;
    found_d     = found_q;
    win_d       = win_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    clear       = 1'b0;
    map_clr     = 1'b0;
    rank_we     = 1'b0;
    unique case (state_q)
      S_INIT: begin
        // Zero the value map once after reset; u wraps back to 0 at the end.
        map_clr = 1'b1;
        u_d     = u_q + PIXEL_BITS'(1);
        if (u_q == '1) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (pix_take && pix_i.last_pixel) begin
          u_d     = '0;
          acc_d   = '0;
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        // Issue the read of value 0 after the last pixel's map write landed.
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        // Write the rank for value u, count u if it occurred, then zero it.
        rank_we = 1'b1;
        map_clr = 1'b1;
        acc_d   = acc_q + TYPE_W'(map_bit);
        u_d     = u_q + PIXEL_BITS'(1);
        if (u_q == '1) begin
          k_d     = '0;
          emit_d  = 1'b0;
          found_d = 1'b0;
          state_d = (status.run_cnt == '0) ? S_CLEAR : S_VAL;
        end
      end
      S_VAL: begin
        state_d = S_RANK;
      end
      S_RANK: begin
        state_d = S_USE;
      end
      S_USE: begin
        if (!emit_q) begin
          // Type pass: slide the window and check it once it is full.
          win_d = win_shift;
          if ((k_q >= IDX_W'(PAT_LEN - 1)) && (win_shift == pattern)) begin
            found_d = 1'b1;
          end
          if (k_last) begin
            k_d    = '0;
            emit_d = 1'b1;
          end else begin
            k_d = k_next[IDX_W-1:0];
          end
          state_d = S_VAL;
        end else begin
          out_d.segment_index = k_next;
          out_d.segment_type  = run_type;
          out_d.pixel_count   = rec.len;
          out_d.midpoint      = rec.start + START_W'((rec.len - LEN_W'(1)) >> 1);
          out_d.pattern_found = found_q;
          out_d.overflow      = status.overflow;
          out_d.last_segment  = k_last;
          out_valid_d         = 1'b1;
          state_d             = S_HOLD;
        end
      end
      S_HOLD: begin
        if (seg_o.ready) begin
          out_valid_d = 1'b0;
          if (out_q.last_segment) begin
            state_d = S_CLEAR;
          end else begin
            k_d     = k_next[IDX_W-1:0];
            state_d = S_VAL;
          end
        end
      end
      S_CLEAR: begin
        // Drop all per-row state before the next row.
        clear   = 1'b1;
        state_d = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      u_q         <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      emit_q      <= 1'b0;
      found_q     <= 1'b0;
      win_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      u_q         <= u_d;
      acc_q       <= acc_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      found_q     <= found_d;
      win_q       <= win_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign seg_o.valid         = out_valid_q;
  assign seg_o.segment_index = out_q.segment_index;
  assign seg_o.segment_type  = out_q.segment_type;
  assign seg_o.pixel_count   = out_q.pixel_count;
  assign seg_o.midpoint      = out_q.midpoint;
  assign seg_o.pattern_found = out_q.pattern_found;
  assign seg_o.overflow      = out_q.overflow;
  assign seg_o.last_segment  = out_q.last_segment;

endmodule
